// ===== hw/rtl/pdc_pkg.sv =====
// Shared types and constants of the PID controller with deadband and clamp.
// Holds the beat payload structs and the configuration register indexes.
// No dependencies.
package pdc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_GAIN_P       = 3'd0;
    localparam cfg_idx_t REG_GAIN_I       = 3'd1;
    localparam cfg_idx_t REG_GAIN_D       = 3'd2;
    localparam cfg_idx_t REG_SETPOINT     = 3'd3;
    localparam cfg_idx_t REG_DEADBAND     = 3'd4;
    localparam cfg_idx_t REG_OUTPUT_LIMIT = 3'd5;

    localparam logic [30:0] OUTPUT_LIMIT_RESET = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [15:0] measurement;
        logic        [15:0] elapsed_ticks;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               clamped;
        logic               settled;
    } out_beat_t;

endpackage

// ===== hw/rtl/pid_controller_deadband_clamp_unit.sv =====
// Top level of the PID controller with deadband and symmetric output clamp.
// Holds the sequencer, the shared multiplier and adder and the serial divider.
// Depends on pdc_pkg.

// One input beat is handled at a time. The first sample after reset or a
// setpoint write skips the divider and the integral step, and a zero
// elapsed_ticks skips the divider. One shared 33 by 25 bit multiplier forms
// five products that are each registered; the integral one is added into the
// saturating 48-bit sum, the other four into an 80-bit accumulator. A
// restoring divider forms the 17-bit derivative quotient one bit per cycle. A
// finished result waits in the output register while the next beat is taken;
// the last step holds only while that register is full and m_ready is low.
module pid_controller_deadband_clamp_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  pdc_pkg::in_beat_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output pdc_pkg::out_beat_t           m_data,
    input  logic                         cfg_we,
    input  pdc_pkg::cfg_idx_t            cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pdc_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_DIV     = 14'b00000000000010,
        ST_INT_MUL = 14'b00000000000100,
        ST_INT_ADD = 14'b00000000001000,
        ST_SIGN    = 14'b00000000010000,
        ST_PE_MUL  = 14'b00000000100000,
        ST_PE_ADD  = 14'b00000001000000,
        ST_GD_MUL  = 14'b00000010000000,
        ST_GD_ADD  = 14'b00000100000000,
        ST_GL_MUL  = 14'b00001000000000,
        ST_GL_ADD  = 14'b00010000000000,
        ST_GH_MUL  = 14'b00100000000000,
        ST_GH_ADD  = 14'b01000000000000,
        ST_FINAL   = 14'b10000000000000
    } state_t;

    state_t             state_reg, state_next;

    logic signed [31:0] gain_p_reg, gain_p_next;
    logic signed [31:0] gain_i_reg, gain_i_next;
    logic signed [31:0] gain_d_reg, gain_d_next;
    logic signed [15:0] setpoint_reg, setpoint_next;
    logic        [15:0] deadband_reg, deadband_next;
    logic        [30:0] limit_reg, limit_next;

    logic signed [47:0] sum_reg, sum_next;
    logic signed [16:0] last_err_reg, last_err_next;
    logic               first_reg, first_next;

    logic signed [16:0] err_reg, err_next;
    logic        [15:0] dt_reg, dt_next;
    logic               dneg_reg, dneg_next;
    logic        [16:0] rem_reg, rem_next;
    logic        [16:0] quo_reg, quo_next;
    logic        [4:0]  cnt_reg, cnt_next;
    logic signed [17:0] deriv_reg, deriv_next;

    logic signed [57:0] prod_reg, prod_next;
    logic signed [79:0] acc_reg, acc_next;

    logic               m_valid_reg, m_valid_next;
    out_beat_t          m_data_reg, m_data_next;

    logic signed [16:0] in_err;
    logic signed [17:0] in_diff;
    logic        [17:0] in_diff_mag;
    logic        [16:0] div_shift;
    logic        [17:0] div_trial;
    logic        [16:0] div_quo;
    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [57:0] mul_p;
    logic signed [79:0] add_a;
    logic signed [79:0] add_b;
    logic signed [79:0] add_s;
    logic signed [47:0] add_sat;
    logic signed [63:0] total;
    logic signed [63:0] lim_ext;
    logic        [31:0] neg_lim;
    logic        [16:0] err_mag;
    logic               sign_change;
    logic               out_free;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign in_err      = 17'(setpoint_reg) - 17'(s_data.measurement);
    assign in_diff     = 18'(in_err) - 18'(last_err_reg);
    assign in_diff_mag = in_diff[17] ? -in_diff : in_diff;

    assign div_shift = {rem_reg[15:0], quo_reg[16]};
    assign div_trial = {1'b0, div_shift} - {2'b00, dt_reg};
    assign div_quo   = {quo_reg[15:0], ~div_trial[17]};

    assign mul_p = mul_a * mul_b;
    assign add_s = add_a + add_b;

    assign add_sat = ((&add_s[79:47]) || !(|add_s[79:47])) ? add_s[47:0]
                   : (add_s[79] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});

    assign total   = acc_reg[79:16];
    assign lim_ext = {33'd0, limit_reg};
    assign neg_lim = -{1'b0, limit_reg};
    assign err_mag = err_reg[16] ? -err_reg : err_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign sign_change = (last_err_reg[16] != err_reg[16])
                      || ((last_err_reg == 17'sd0) != (err_reg == 17'sd0));

    always_comb begin
        mul_a = {gain_p_reg[31], gain_p_reg};
        mul_b = 25'(err_reg);
        case (state_reg)
            ST_INT_MUL: begin
                mul_a = 33'(err_reg);
                mul_b = {9'd0, dt_reg};
            end
            ST_GD_MUL: begin
                mul_a = {gain_d_reg[31], gain_d_reg};
                mul_b = 25'(deriv_reg);
            end
            ST_GL_MUL: begin
                mul_a = {gain_i_reg[31], gain_i_reg};
                mul_b = {1'b0, sum_reg[23:0]};
            end
            ST_GH_MUL: begin
                mul_a = {gain_i_reg[31], gain_i_reg};
                mul_b = {sum_reg[47], sum_reg[47:24]};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        add_a = (state_reg == ST_INT_ADD) ? 80'(sum_reg) : acc_reg;
        add_b = (state_reg == ST_GH_ADD) ? {prod_reg[55:0], 24'd0} : 80'(prod_reg);
    end

    always_comb begin
        state_next    = state_reg;
        gain_p_next   = gain_p_reg;
        gain_i_next   = gain_i_reg;
        gain_d_next   = gain_d_reg;
        setpoint_next = setpoint_reg;
        deadband_next = deadband_reg;
        limit_next    = limit_reg;
        sum_next      = sum_reg;
        last_err_next = last_err_reg;
        first_next    = first_reg;
        err_next      = err_reg;
        dt_next       = dt_reg;
        dneg_next     = dneg_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        deriv_next    = deriv_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        if (cfg_we) begin
            case (cfg_index)
                REG_GAIN_P: gain_p_next = cfg_data;
                REG_GAIN_I: gain_i_next = cfg_data;
                REG_GAIN_D: gain_d_next = cfg_data;
                REG_SETPOINT: begin
                    setpoint_next = cfg_data[15:0];
                    sum_next      = 48'sd0;
                    last_err_next = 17'sd0;
                    first_next    = 1'b1;
                end
                REG_DEADBAND:     deadband_next = cfg_data[15:0];
                REG_OUTPUT_LIMIT: limit_next    = cfg_data[30:0];
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    err_next   = in_err;
                    dt_next    = s_data.elapsed_ticks;
                    dneg_next  = in_diff[17];
                    rem_next   = 17'd0;
                    quo_next   = in_diff_mag[16:0];
                    cnt_next   = 5'd0;
                    deriv_next = 18'sd0;
                    first_next = 1'b0;
                    if (first_reg) begin
                        state_next = ST_SIGN;
                    end else if (s_data.elapsed_ticks == 16'd0) begin
                        state_next = ST_INT_MUL;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next = div_trial[17] ? div_shift : div_trial[16:0];
                quo_next = div_quo;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16) begin
                    deriv_next = dneg_reg ? -{1'b0, div_quo} : {1'b0, div_quo};
                    state_next = ST_INT_MUL;
                end
            end
            ST_INT_MUL: begin
                prod_next  = mul_p;
                state_next = ST_INT_ADD;
            end
            ST_INT_ADD: begin
                sum_next   = add_sat;
                state_next = ST_SIGN;
            end
            ST_SIGN: begin
                if (sign_change) begin
                    sum_next = 48'sd0;
                end
                last_err_next = err_reg;
                acc_next      = 80'sd0;
                state_next    = ST_PE_MUL;
            end
            ST_PE_MUL: begin
                prod_next  = mul_p;
                state_next = ST_PE_ADD;
            end
            ST_PE_ADD: begin
                acc_next   = add_s;
                state_next = ST_GD_MUL;
            end
            ST_GD_MUL: begin
                prod_next  = mul_p;
                state_next = ST_GD_ADD;
            end
            ST_GD_ADD: begin
                acc_next   = add_s;
                state_next = ST_GL_MUL;
            end
            ST_GL_MUL: begin
                prod_next  = mul_p;
                state_next = ST_GL_ADD;
            end
            ST_GL_ADD: begin
                acc_next   = add_s;
                state_next = ST_GH_MUL;
            end
            ST_GH_MUL: begin
                prod_next  = mul_p;
                state_next = ST_GH_ADD;
            end
            ST_GH_ADD: begin
                acc_next   = add_s;
                state_next = ST_FINAL;
            end
            ST_FINAL: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_data_next.settled = 1'b0;
                    if (err_mag < {1'b0, deadband_reg}) begin
                        m_data_next.drive   = 32'sd0;
                        m_data_next.clamped = 1'b0;
                        m_data_next.settled = 1'b1;
                        sum_next            = 48'sd0;
                    end else if (total > lim_ext) begin
                        m_data_next.drive   = {1'b0, limit_reg};
                        m_data_next.clamped = 1'b1;
                    end else if (total < -lim_ext) begin
                        m_data_next.drive   = neg_lim;
                        m_data_next.clamped = 1'b1;
                    end else begin
                        m_data_next.drive   = total[31:0];
                        m_data_next.clamped = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            gain_p_reg   <= 32'sd0;
            gain_i_reg   <= 32'sd0;
            gain_d_reg   <= 32'sd0;
            setpoint_reg <= 16'sd0;
            deadband_reg <= 16'd0;
            limit_reg    <= OUTPUT_LIMIT_RESET;
            sum_reg      <= 48'sd0;
            last_err_reg <= 17'sd0;
            first_reg    <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            gain_p_reg   <= gain_p_next;
            gain_i_reg   <= gain_i_next;
            gain_d_reg   <= gain_d_next;
            setpoint_reg <= setpoint_next;
            deadband_reg <= deadband_next;
            limit_reg    <= limit_next;
            sum_reg      <= sum_next;
            last_err_reg <= last_err_next;
            first_reg    <= first_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg    <= err_next;
        dt_reg     <= dt_next;
        dneg_reg   <= dneg_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        deriv_reg  <= deriv_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== hw/rtl/pdc_checker.sv =====
// Port-level checks of the PID controller with deadband and clamp.
// Attached to the top level by the bind statement below; depends on pdc_pkg.
module pdc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input pdc_pkg::out_beat_t             m_data
);
    import pdc_pkg::*;

    // A result beat that is not taken stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // An accepted input beat keeps the block busy for at least the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again right after a beat");

    // A settled result carries a zero drive and no clamp flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.settled |-> m_data.drive == 32'sd0 && !m_data.clamped)
        else $error("settled result with nonzero drive or clamp");

    // A new result appears only while the block is busy with an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while the block was idle");

endmodule

bind pid_controller_deadband_clamp_unit pdc_checker u_pdc_checker (.*);
